FILE: hw/rtl/tbi_pkg.sv
// shared constants and types for the trajectory box intersect block
package tbi_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int CFG_IDX_BITS   = 3;
    localparam int T_BITS         = 18;

    localparam logic [CFG_IDX_BITS-1:0] REG_X_LOW  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_X_HIGH = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_LOW  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_Y_HIGH = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_Z_LOW  = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_Z_HIGH = 3'd5;

    // controller to datapath
    typedef struct packed {
        logic       load;      // capture new point, start segment
        logic       setup;     // form d and numerators for one axis
        logic [1:0] axis;
        logic       bound_hi;  // which numerator goes to the divider
        logic       div_start;
        logic       merge;     // fold both t values into the interval
        logic       finish;    // commit segment result, advance prior point
        logic       seg_hit;   // segment verdict, valid with finish
    } tbi_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic have_prior;
        logic quick_hit;   // box valid and an end point strictly inside
        logic quick_miss;  // inverted box
        logic axis_zero;   // d == 0 on the set-up axis
        logic axis_reject; // prior point outside the slab on the set-up axis
        logic div_done;
        logic empty;       // interval became empty
        logic eot;
    } tbi_stat_t;

endpackage

FILE: hw/rtl/trajectory_box_intersect.sv
// top level: trajectory segment versus box test
//
//  channel   dir  handshake          payload
//  input     in   in_valid/in_stall  pos_x pos_y pos_z end_of_track
//  result    out  out_valid/out_stall crosses_box
//  config    in   cfg_write          cfg_index cfg_data
//
// a point with no prior point or a quick verdict skips the divider; a full
// segment takes up to six divisions, two per axis, on the shared bit-serial
// divider, and the last point of a track also passes through an output state.
// reset clears the box, prior point and sticky hit.
// a pending result holds off further points until it is taken.
module trajectory_box_intersect #(
    parameter int COORD_BITS = tbi_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [tbi_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COORD_BITS-1:0]            cfg_data,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [COORD_BITS-1:0]     pos_x,
    input  logic signed [COORD_BITS-1:0]     pos_y,
    input  logic signed [COORD_BITS-1:0]     pos_z,
    input  logic                             end_of_track,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             crosses_box
);
    import tbi_pkg::*;

    tbi_cmd_t  cmd;
    tbi_stat_t stat;
    logic      hit;
    logic      res_reg;

    tbi_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .stat      (stat),
        .cmd       (cmd)
    );

    tbi_datapath #(.COORD_BITS(COORD_BITS)) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .end_of_track (end_of_track),
        .cmd          (cmd),
        .stat         (stat),
        .hit          (hit)
    );

    // result captured when the last point's segment commits
    always_ff @(posedge clk)
        if (cmd.finish && stat.eot)
            res_reg <= hit;

    assign crosses_box = res_reg;
endmodule

FILE: hw/rtl/tbi_div.sv
// restoring divider, one quotient bit per cycle, saturated unsigned Q2.16 result
module tbi_div #(
    parameter int NUM_BITS = 26
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [NUM_BITS-1:0]        num,
    input  logic [NUM_BITS-1:0]        den,
    output logic                       done,
    output logic [tbi_pkg::T_BITS-1:0] t_sat
);
    import tbi_pkg::*;

    localparam int QB  = NUM_BITS + 16;
    localparam int CNT = $clog2(QB + 1);

    logic [QB-1:0]       dvd_reg, dvd_next;
    logic [NUM_BITS:0]   rem_reg, rem_next;
    logic [NUM_BITS-1:0] den_reg;
    logic [CNT-1:0]      cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [NUM_BITS:0]   shifted;
    logic [NUM_BITS:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg[NUM_BITS-1:0], dvd_reg[QB-1]};
        diff      = shifted - {1'b0, den_reg};
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        // quotient is complete the cycle after the last step
        done_next = busy_reg && !start && (cnt_reg == CNT'(1));
        if (start)
        begin
            dvd_next  = {num, 16'd0};
            rem_next  = '0;
            cnt_next  = CNT'(QB);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[NUM_BITS])
            begin
                rem_next = diff;
                dvd_next = {dvd_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted;
                dvd_next = {dvd_reg[QB-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (start)
            den_reg <= den;
    end

    assign done = done_reg;

    // quotient above 1.0 saturates to 65537
    always_comb
    begin
        if (dvd_reg[QB-1:17] != '0 || (dvd_reg[16] && dvd_reg[15:0] != '0))
            t_sat = T_BITS'(65537);
        else
            t_sat = T_BITS'(dvd_reg[16:0]);
    end
endmodule

FILE: hw/rtl/tbi_datapath.sv
// segment datapath: point registers, box compares, divider and interval
module tbi_datapath #(
    parameter int COORD_BITS = tbi_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [tbi_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [COORD_BITS-1:0]             cfg_data,
    input  logic signed [COORD_BITS-1:0]      pos_x,
    input  logic signed [COORD_BITS-1:0]      pos_y,
    input  logic signed [COORD_BITS-1:0]      pos_z,
    input  logic                              end_of_track,
    input  tbi_pkg::tbi_cmd_t                 cmd,
    output tbi_pkg::tbi_stat_t                stat,
    output logic                              hit
);
    import tbi_pkg::*;

    localparam int NB = COORD_BITS + 2;

    logic signed [COORD_BITS-1:0] lo_reg [3];
    logic signed [COORD_BITS-1:0] hi_reg [3];
    logic signed [COORD_BITS-1:0] prior_reg [3];
    logic signed [COORD_BITS-1:0] cur_reg [3];
    logic have_prior_reg, eot_reg, hit_reg;
    logic [NB-1:0] nlo_reg, nhi_reg, d_reg;
    logic axis_zero_reg, axis_rej_reg;
    logic signed [T_BITS:0] tmin_reg, tmax_reg, t1_reg;
    logic signed [T_BITS:0] t2, ta, tb, tmin_n, tmax_n;
    logic in_a, in_b, inverted;
    logic signed [COORD_BITS-1:0] a_sel, b_sel, l_sel, h_sel;
    logic signed [NB-1:0] dd, nl, nh;
    logic [NB-1:0] num_sel;
    logic div_done;
    logic [T_BITS-1:0] t_div;
    logic [T_BITS-1:0] t_q;
    logic hit_now;
    logic neg_num_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                lo_reg[i]    <= '0;
                hi_reg[i]    <= '0;
                prior_reg[i] <= '0;
            end
            have_prior_reg <= 1'b0;
            hit_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_X_LOW:  lo_reg[0] <= cfg_data;
                    REG_X_HIGH: hi_reg[0] <= cfg_data;
                    REG_Y_LOW:  lo_reg[1] <= cfg_data;
                    REG_Y_HIGH: hi_reg[1] <= cfg_data;
                    REG_Z_LOW:  lo_reg[2] <= cfg_data;
                    REG_Z_HIGH: hi_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.finish)
            begin
                prior_reg      <= cur_reg;
                have_prior_reg <= !eot_reg;
                // sticky hit starts over after the last point of a track
                hit_reg        <= eot_reg ? 1'b0 : (hit_reg | hit_now);
            end
        end
    end

    // per-segment working registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cur_reg[0] <= pos_x;
            cur_reg[1] <= pos_y;
            cur_reg[2] <= pos_z;
            eot_reg    <= end_of_track;
            tmin_reg   <= '0;
            tmax_reg   <= (T_BITS+1)'(65536);
        end
        if (cmd.setup)
        begin
            nlo_reg       <= (dd < 0) ? NB'(-nl) : NB'(nl);
            nhi_reg       <= (dd < 0) ? NB'(-nh) : NB'(nh);
            d_reg         <= (dd < 0) ? NB'(-dd) : NB'(dd);
            axis_zero_reg <= (dd == 0);
            axis_rej_reg  <= (a_sel < l_sel) || (a_sel > h_sel);
        end
        if (div_done && !cmd.bound_hi)
            t1_reg <= {1'b0, t_q};
        if (cmd.merge)
        begin
            tmin_reg <= tmin_n;
            tmax_reg <= tmax_n;
        end
    end

    assign hit_now = have_prior_reg && cmd.finish && cmd.seg_hit;

    always_comb
    begin
        a_sel = prior_reg[cmd.axis];
        b_sel = cur_reg[cmd.axis];
        l_sel = lo_reg[cmd.axis];
        h_sel = hi_reg[cmd.axis];
    end

    assign dd = NB'(b_sel) - NB'(a_sel);
    assign nl = NB'(l_sel) - NB'(a_sel);
    assign nh = NB'(h_sel) - NB'(a_sel);

    assign num_sel = cmd.bound_hi ? nhi_reg : nlo_reg;

    // negative numerator saturates below zero; the divider runs on a zero numerator
    always_ff @(posedge clk)
        if (cmd.div_start)
            neg_num_reg <= num_sel[NB-1];

    tbi_div #(.NUM_BITS(NB)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_sel[NB-1] ? '0 : num_sel),
        .den   (d_reg),
        .done  (div_done),
        .t_sat (t_div)
    );

    assign t_q = neg_num_reg ? '1 : t_div;

    always_comb
    begin
        t2 = neg_num_reg ? -(T_BITS+1)'(1) : {1'b0, t_div};
        ta = (t1_reg[T_BITS-1:0] == '1) ? -(T_BITS+1)'(1) : t1_reg;
        tb = t2;
        if (ta > tb)
        begin
            tb = ta;
            ta = t2;
        end
        tmin_n = (ta > tmin_reg) ? ta : tmin_reg;
        tmax_n = (tb < tmax_reg) ? tb : tmax_reg;
    end

    always_comb
    begin
        inverted = 1'b0;
        in_a = 1'b1;
        in_b = 1'b1;
        for (int i = 0; i < 3; i++)
        begin
            if (lo_reg[i] > hi_reg[i])
                inverted = 1'b1;
            if (!(prior_reg[i] > lo_reg[i] && prior_reg[i] < hi_reg[i]))
                in_a = 1'b0;
            if (!(cur_reg[i] > lo_reg[i] && cur_reg[i] < hi_reg[i]))
                in_b = 1'b0;
        end
    end

    always_comb
    begin
        stat.have_prior  = have_prior_reg;
        stat.quick_miss  = inverted;
        stat.quick_hit   = !inverted && (in_a || in_b);
        stat.axis_zero   = axis_zero_reg;
        stat.axis_reject = axis_rej_reg;
        stat.div_done    = div_done;
        stat.empty       = tmin_reg > tmax_reg;
        stat.eot         = eot_reg;
    end

    assign hit = hit_reg | hit_now;
endmodule

FILE: hw/rtl/tbi_ctrl.sv
// sequencer for one segment test
module tbi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               out_stall,
    output logic               out_valid,
    input  tbi_pkg::tbi_stat_t stat,
    output tbi_pkg::tbi_cmd_t  cmd
);
    import tbi_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_CHECK = 8'b0000_0010,
        S_SETUP = 8'b0000_0100,
        S_AXIS  = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_MERGE = 8'b0010_0000,
        S_DONE  = 8'b0100_0000,
        S_OUT   = 8'b1000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] axis_reg, axis_next;
    logic       bhi_reg, bhi_next;
    logic       hit_reg, hit_next;
    logic       ov_reg, ov_next;

    always_comb
    begin
        state_next = state_reg;
        axis_next  = axis_reg;
        bhi_next   = bhi_reg;
        hit_next   = hit_reg;
        ov_next    = ov_reg && out_stall;
        cmd        = '0;
        cmd.axis   = axis_reg;
        cmd.bound_hi = bhi_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && !ov_reg)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                axis_next = 2'd0;
                hit_next  = 1'b0;
                if (!stat.have_prior || stat.quick_miss)
                    state_next = S_DONE;
                else if (stat.quick_hit)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                    state_next = S_SETUP;
            end
            S_SETUP:
            begin
                cmd.setup  = 1'b1;
                state_next = S_AXIS;
            end
            S_AXIS:
            begin
                if (stat.axis_zero)
                begin
                    if (stat.axis_reject)
                        state_next = S_DONE;
                    else if (axis_reg == 2'd2)
                    begin
                        hit_next   = 1'b1;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        axis_next  = axis_reg + 2'd1;
                        state_next = S_SETUP;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    if (!bhi_reg)
                    begin
                        bhi_next   = 1'b1;
                        state_next = S_AXIS;
                    end
                    else
                    begin
                        cmd.merge  = 1'b1;
                        bhi_next   = 1'b0;
                        state_next = S_MERGE;
                    end
                end
            end
            S_MERGE:
            begin
                if (stat.empty)
                    state_next = S_DONE;
                else if (axis_reg == 2'd2)
                begin
                    hit_next   = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    axis_next  = axis_reg + 2'd1;
                    state_next = S_SETUP;
                end
            end
            S_DONE:
            begin
                cmd.finish  = 1'b1;
                cmd.seg_hit = hit_reg;
                state_next  = stat.eot ? S_OUT : S_IDLE;
            end
            S_OUT:
            begin
                ov_next    = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            axis_reg  <= '0;
            bhi_reg   <= 1'b0;
            hit_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            bhi_reg   <= bhi_next;
            hit_reg   <= hit_next;
            ov_reg    <= ov_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || ov_reg;
    assign out_valid = ov_reg;
endmodule
